>>> src/ptb_pkg.sv
// ----------------------------------------------------------------------------
// ptb_pkg
// shared types and constants of the periodic timer bank
// ----------------------------------------------------------------------------
`default_nettype none

package ptb_pkg;

  localparam int NumTimers = 8;
  localparam int TimerW    = 32;
  localparam int TickW     = 64;
  localparam int SlotW     = 4;
  localparam int FireW     = 8;

  typedef enum logic [2:0] {
    CmdTick       = 3'd0,
    CmdRegister   = 3'd1,
    CmdUnregister = 3'd2,
    CmdChange     = 3'd3,
    CmdEnable     = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StFull    = 2'd1,
    StBadSlot = 2'd2
  } status_e;

  typedef struct packed {
    logic [2:0]        command;
    logic [SlotW-1:0]  slot;
    logic [TimerW-1:0] period;
    logic              enable;
  } item_t;

  typedef struct packed {
    logic [TickW-1:0] tick_count;
    logic [1:0]       status;
    logic [SlotW-1:0] slot_out;
    logic [FireW-1:0] fire_mask;
  } result_t;

  // per-timer operation select
  typedef struct packed {
    logic tick;
    logic load;
    logic unreg;
    logic reload_only;
    logic set_en;
    logic en_val;
  } tmr_ctl_t;

endpackage

`default_nettype wire

>>> src/ptb_decode.sv
// ----------------------------------------------------------------------------
// ptb_decode
// command decode: free slot search, slot check, status and per-timer controls
// ----------------------------------------------------------------------------
`default_nettype none

module ptb_decode (
  input  var ptb_pkg::item_t               item_i,
  input  wire [ptb_pkg::NumTimers-1:0]     alloc_i,
  output ptb_pkg::tmr_ctl_t                ctl_o [ptb_pkg::NumTimers],
  output logic [ptb_pkg::SlotW-1:0]        slot_out_o,
  output logic [1:0]                       status_o
);

  logic                          slot_ok;
  logic [5:0]                    slot_m1;
  logic [ptb_pkg::NumTimers-1:0] hit;
  logic [ptb_pkg::NumTimers-1:0] grant;
  logic                          found;
  logic                          hit_any;
  logic [ptb_pkg::SlotW-1:0]     free_slot;

  assign slot_ok = (item_i.slot != '0) && (32'(item_i.slot) <= ptb_pkg::NumTimers);
  assign slot_m1 = 6'(item_i.slot) - 6'd1;

  always_comb begin
    found     = 1'b0;
    grant     = '0;
    free_slot = '0;
    // lowest free slot wins
    for (int i = 0; i < ptb_pkg::NumTimers; i++) begin
      if (!alloc_i[i] && !found) begin
        found     = 1'b1;
        grant[i]  = 1'b1;
        free_slot = ptb_pkg::SlotW'(i + 1);
      end
    end
    for (int i = 0; i < ptb_pkg::NumTimers; i++) begin
      hit[i] = slot_ok && (slot_m1 == 6'(i)) && alloc_i[i];
    end
    hit_any = |hit;
  end

  always_comb begin
    status_o   = ptb_pkg::StOk;
    slot_out_o = '0;
    for (int i = 0; i < ptb_pkg::NumTimers; i++) begin
      ctl_o[i] = '0;
      ctl_o[i].en_val = item_i.enable;
    end
    unique case (item_i.command)
      ptb_pkg::CmdTick: begin
        for (int i = 0; i < ptb_pkg::NumTimers; i++) ctl_o[i].tick = 1'b1;
      end
      ptb_pkg::CmdRegister: begin
        if (!found) status_o = ptb_pkg::StFull;
        // free_slot stays zero when the bank is full
        slot_out_o = free_slot;
        for (int i = 0; i < ptb_pkg::NumTimers; i++) ctl_o[i].load = grant[i];
      end
      ptb_pkg::CmdUnregister: begin
        if (!hit_any) status_o = ptb_pkg::StBadSlot;
        for (int i = 0; i < ptb_pkg::NumTimers; i++) ctl_o[i].unreg = hit[i];
      end
      ptb_pkg::CmdChange: begin
        if (!hit_any) status_o = ptb_pkg::StBadSlot;
        for (int i = 0; i < ptb_pkg::NumTimers; i++) ctl_o[i].reload_only = hit[i];
      end
      ptb_pkg::CmdEnable: begin
        if (!hit_any) status_o = ptb_pkg::StBadSlot;
        for (int i = 0; i < ptb_pkg::NumTimers; i++) ctl_o[i].set_en = hit[i];
      end
      default: begin
        // unused command codes leave everything alone
        status_o = ptb_pkg::StOk;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> src/ptb_timer.sv
// ----------------------------------------------------------------------------
// ptb_timer
// one reloadable down-counting timer channel
// ----------------------------------------------------------------------------
`default_nettype none

module ptb_timer (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          commit_i,
  input  var ptb_pkg::tmr_ctl_t        ctl_i,
  input  wire [ptb_pkg::TimerW-1:0]    period_i,
  output logic                         alloc_o,
  output logic                         fire_o
);

  logic                       alloc_q, alloc_d;
  logic                       en_q, en_d;
  logic [ptb_pkg::TimerW-1:0] reload_q, reload_d;
  logic [ptb_pkg::TimerW-1:0] count_q, count_d;
  logic [ptb_pkg::TimerW-1:0] dec;

  assign dec = count_q - 1'b1;

  always_comb begin
    alloc_d  = alloc_q;
    en_d     = en_q;
    reload_d = reload_q;
    count_d  = count_q;
    fire_o   = 1'b0;
    if (ctl_i.tick && alloc_q && en_q) begin
      if (dec == '0) begin
        fire_o  = 1'b1;
        count_d = reload_q;
      end else begin
        count_d = dec;
      end
    end
    if (ctl_i.load) begin
      alloc_d  = 1'b1;
      en_d     = 1'b1;
      reload_d = period_i;
      count_d  = period_i;
    end
    if (ctl_i.unreg) begin
      alloc_d = 1'b0;
      en_d    = 1'b0;
    end
    if (ctl_i.reload_only) begin
      reload_d = period_i;
      count_d  = period_i;
    end
    if (ctl_i.set_en) begin
      en_d = ctl_i.en_val;
      if (ctl_i.en_val) count_d = reload_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alloc_q <= 1'b0;
      en_q    <= 1'b0;
    end else if (commit_i) begin
      alloc_q <= alloc_d;
      en_q    <= en_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit_i) begin
      reload_q <= reload_d;
      count_q  <= count_d;
    end
  end

  assign alloc_o = alloc_q;

endmodule

`default_nettype wire

>>> src/periodic_timer_bank.sv
// ----------------------------------------------------------------------------
// periodic_timer_bank
// bank of reloadable down-counting timers driven by instruction ticks
// ----------------------------------------------------------------------------
// usage:
//   each transaction on the slave stream carries one command in tuser
//   (tick, register, unregister, change period, set enable) with slot,
//   period and enable in tdata. every command gives exactly one result
//   transaction on the master stream: fire mask, granted slot, status and
//   the running tick count.
//   the input item is captured in an input register, then the decode and
//   every timer channel update in parallel and the result lands in an
//   output register. one item is accepted every cycle while the receiver
//   takes the results; all channel counters and the 64-bit tick counter
//   update together for each item.
//   reset clears all slots to free and disabled and the tick count to zero.
//   when the receiver stalls, the result stays in the output register, one
//   more item waits in the input register, and s_axis_tready then drops
//   until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_timer_bank (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // [3:0] slot, [35:4] period, [36] enable, [39:37] zero
  input  wire  [39:0] s_axis_tdata,
  // [2:0] command
  input  wire  [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // [7:0] fire_mask, [11:8] slot_out, [13:12] status, [77:14] tick_count,
  // [79:78] zero
  output logic [79:0] m_axis_tdata
);

  ptb_pkg::item_t            in_q;
  logic                      in_valid_q, in_valid_d;
  logic                      out_valid_q, out_valid_d;
  ptb_pkg::result_t          res_q, res_d;
  logic [ptb_pkg::TickW-1:0] tick_q, tick_d;
  logic                      advance;
  logic                      s_accept;
  logic                      is_tick;

  ptb_pkg::tmr_ctl_t             ctl [ptb_pkg::NumTimers];
  logic [ptb_pkg::NumTimers-1:0] alloc;
  logic [ptb_pkg::NumTimers-1:0] fire;
  logic [ptb_pkg::SlotW-1:0]     slot_out;
  logic [1:0]                    status;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_accept) in_valid_d = 1'b1;
    else if (advance) in_valid_d = 1'b0;
    out_valid_d = out_valid_q;
    if (advance) out_valid_d = 1'b1;
    else if (m_axis_tready) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      tick_q      <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) tick_q <= tick_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_q.command <= s_axis_tuser;
      in_q.slot    <= s_axis_tdata[3:0];
      in_q.period  <= s_axis_tdata[35:4];
      in_q.enable  <= s_axis_tdata[36];
    end
    if (advance) res_q <= res_d;
  end

  ptb_decode u_decode (
    .item_i     (in_q),
    .alloc_i    (alloc),
    .ctl_o      (ctl),
    .slot_out_o (slot_out),
    .status_o   (status)
  );

  for (genvar g = 0; g < ptb_pkg::NumTimers; g++) begin : g_timer
    ptb_timer u_timer (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .commit_i (advance),
      .ctl_i    (ctl[g]),
      .period_i (in_q.period),
      .alloc_o  (alloc[g]),
      .fire_o   (fire[g])
    );
  end

  assign is_tick = (in_q.command == ptb_pkg::CmdTick);
  assign tick_d  = tick_q + ptb_pkg::TickW'(is_tick);

  always_comb begin
    res_d = '0;
    // timers past the mask width run but report nothing
    for (int i = 0; i < ptb_pkg::NumTimers; i++) begin
      if (i < ptb_pkg::FireW) res_d.fire_mask[i % ptb_pkg::FireW] = fire[i];
    end
    res_d.slot_out   = slot_out;
    res_d.status     = status;
    res_d.tick_count = tick_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, res_q};

endmodule

`default_nettype wire
